>>> rtl/imhq_pkg.sv
package imhq_pkg;

    localparam int IDENT_BITS = 10;
    localparam int KEY_W      = 32;
    localparam int COUNT_BITS = 11;
    localparam int IDENT_SPACE = 1024;

    localparam logic [1:0] KIND_CLEAR    = 2'd0;
    localparam logic [1:0] KIND_INSERT   = 2'd1;
    localparam logic [1:0] KIND_EXTRACT  = 2'd2;
    localparam logic [1:0] KIND_DECREASE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BAD_ID   = 3'd3;
    localparam logic [2:0] ST_INCREASE = 3'd4;

    typedef struct packed {
        logic [1:0]            kind;
        logic [IDENT_BITS-1:0] ident;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]              status;
        logic [IDENT_BITS-1:0]   out_ident;
        logic signed [KEY_W-1:0] out_key;
        logic [COUNT_BITS-1:0]   count;
        logic                    is_empty;
    } rsp_t;

    // Signed order of keys: strict less-than.
    function automatic logic key_lt(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
        return a < b;
    endfunction

endpackage

>>> rtl/imhq_slot_ram.sv
module imhq_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 42
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/indexed_min_heap_queue.sv
// Indexed binary min-heap priority queue with a position map per identifier.
// Input channel (in_valid/in_ready, payload req): one operation per item:
// clear, insert, extract minimum or decrease key.  Output channel
// (out_valid/out_ready, payload rsp): exactly one result item per input
// item, carrying status, removed entry, count and empty flag.
// Configuration: cfg_we/cfg_data writes the capacity register; the user is to
// write it only while idle, and the block has no guard for this.  A clear
// sweeps the position map entry by entry.  Insert and decrease key walk up
// the heap level by level, and extract walks down it.
// The slot memory has one write port and one registered read port: each level
// needs a read of one or two slots, a compare, and two writes.  The block
// handles one item at a time; in_ready is high only when idle, and the next
// item is taken in the cycle after a result loads.  After reset a clearing
// pass sweeps the position map; no item is accepted until it ends, though
// configuration writes are taken.  Capacity resets to 1024.  When the
// receiver stalls, the result holds in the output register and the next item
// is still accepted; its result waits until the held one is taken, and the
// input stalls meanwhile.
module indexed_min_heap_queue #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  imhq_pkg::req_t    req,
    output logic              out_valid,
    input  logic              out_ready,
    output imhq_pkg::rsp_t    rsp,
    input  logic              cfg_we,
    input  logic [imhq_pkg::COUNT_BITS-1:0] cfg_data
);

    localparam int IB = imhq_pkg::IDENT_BITS;
    localparam int KW = imhq_pkg::KEY_W;
    localparam int CB = imhq_pkg::COUNT_BITS;
    localparam int SB = $clog2(MAX_ENTRIES + 1);   // slot number, 0 = absent
    localparam int AB = $clog2(MAX_ENTRIES + 1);   // slot memory address
    localparam int NID = imhq_pkg::IDENT_SPACE;
    localparam int MB = $clog2(NID);
    localparam int SW = IB + KW;

    localparam logic [4:0] S_SWEEP  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DEC_RD = 5'd2;
    localparam logic [4:0] S_DEC_CK = 5'd3;
    localparam logic [4:0] S_UP_RD  = 5'd4;
    localparam logic [4:0] S_UP_CK  = 5'd5;
    localparam logic [4:0] S_UP_W2  = 5'd6;
    localparam logic [4:0] S_EX_RD1 = 5'd7;
    localparam logic [4:0] S_EX_RDL = 5'd8;
    localparam logic [4:0] S_EX_W   = 5'd9;
    localparam logic [4:0] S_DN_RL  = 5'd10;
    localparam logic [4:0] S_DN_RR  = 5'd11;
    localparam logic [4:0] S_DN_CK  = 5'd12;
    localparam logic [4:0] S_DN_W2  = 5'd13;
    localparam logic [4:0] S_DONE   = 5'd14;
    localparam logic [4:0] S_MAP_RD = 5'd15;
    localparam logic [4:0] S_INS_CK = 5'd16;
    localparam logic [4:0] S_INS_W  = 5'd17;
    localparam logic [4:0] S_UP_RD2 = 5'd18;
    localparam logic [4:0] S_DN_RD2 = 5'd19;

    logic [4:0]  state_reg, state_next;
    logic [CB-1:0] cap_reg;
    logic [SB-1:0] cnt_reg, cnt_next;
    logic [MB:0]   sweep_reg;
    logic          boot_reg;                 // set until the reset sweep ends
    imhq_pkg::req_t  op_reg;
    logic [SB-1:0] cur_reg, cur_next;        // slot being sifted
    logic [SW-1:0] cur_val_reg, cur_val_next; // its (ident,key)
    logic [SB-1:0] oth_reg, oth_next;        // parent / chosen child
    logic [SW-1:0] oth_val_reg, oth_val_next;
    logic [2:0]    st_reg, st_next;
    logic [IB-1:0] oid_reg, oid_next;
    logic [KW-1:0] okey_reg, okey_next;
    logic          out_valid_reg;
    imhq_pkg::rsp_t rsp_reg;

    // Position map: ident -> slot.
    logic [SB-1:0] map_mem [NID];
    logic          map_we;
    logic [MB-1:0] map_waddr;
    logic [SB-1:0] map_wdata;
    logic [SB-1:0] map_rdata;
    logic          map_we2;
    logic [MB-1:0] map_waddr2;
    logic [SB-1:0] map_wdata2;

    // Slot memory.
    logic          slot_we;
    logic [AB-1:0] slot_waddr, slot_raddr;
    logic [SW-1:0] slot_wdata, slot_rdata;

    imhq_slot_ram #(.DEPTH(MAX_ENTRIES + 1), .WIDTH(SW)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Second map write port is serialized: map writes happen one per cycle;
    // the second is held in the pend registers until no primary write is due.
    logic          pend_we_reg;
    logic [MB-1:0] pend_addr_reg;
    logic [SB-1:0] pend_data_reg;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        else if (pend_we_reg)
        begin
            map_mem[pend_addr_reg] <= pend_data_reg;
        end
        map_rdata <= map_mem[op_reg.ident];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_we_reg <= 1'b0;
        end
        else
        begin
            pend_we_reg <= map_we2 | (pend_we_reg & map_we);
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we2)
        begin
            pend_addr_reg <= map_waddr2;
            pend_data_reg <= map_wdata2;
        end
    end

    logic [SB-1:0] cap_lim;
    logic [SB-1:0] cap_ext;
    logic signed [KW-1:0] cur_key, oth_key, rd_key;
    logic [IB-1:0] cur_id, oth_id;
    logic          out_free;

    always_comb
    begin
        cap_ext = SB'(cap_reg);
        if (CB > SB && (cap_reg >> SB) != '0)
        begin
            cap_lim = SB'(MAX_ENTRIES);
        end
        else if (cap_ext > SB'(MAX_ENTRIES))
        begin
            cap_lim = SB'(MAX_ENTRIES);
        end
        else
        begin
            cap_lim = cap_ext;
        end
    end

    assign cur_key  = cur_val_reg[KW-1:0];
    assign cur_id   = cur_val_reg[SW-1:KW];
    assign oth_key  = oth_val_reg[KW-1:0];
    assign oth_id   = oth_val_reg[SW-1:KW];
    assign rd_key   = slot_rdata[KW-1:0];
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        cur_val_next = cur_val_reg;
        oth_next     = oth_reg;
        oth_val_next = oth_val_reg;
        st_next      = st_reg;
        oid_next     = oid_reg;
        okey_next    = okey_reg;
        slot_we      = 1'b0;
        slot_waddr   = '0;
        slot_wdata   = '0;
        slot_raddr   = '0;
        map_we       = 1'b0;
        map_waddr    = '0;
        map_wdata    = '0;
        map_we2      = 1'b0;
        map_waddr2   = '0;
        map_wdata2   = '0;
        unique case (state_reg)
            S_SWEEP:
            begin
                map_we    = 1'b1;
                map_waddr = sweep_reg[MB-1:0];
                if (sweep_reg == (MB+1)'(NID - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    st_next   = imhq_pkg::ST_OK;
                    oid_next  = '0;
                    okey_next = '0;
                    unique case (req.kind)
                        imhq_pkg::KIND_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_SWEEP;
                        end
                        imhq_pkg::KIND_INSERT:
                        begin
                            if (cnt_reg >= cap_lim)
                            begin
                                st_next    = imhq_pkg::ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MAP_RD;
                            end
                        end
                        imhq_pkg::KIND_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = imhq_pkg::ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_EX_RD1;
                            end
                        end
                        default:
                        begin
                            state_next = S_MAP_RD;
                        end
                    endcase
                end
            end
            S_MAP_RD:
            begin
                state_next = (op_reg.kind == imhq_pkg::KIND_INSERT) ? S_INS_CK : S_DEC_RD;
            end
            S_INS_CK:
            begin
                if (map_rdata != '0)
                begin
                    st_next    = imhq_pkg::ST_BAD_ID;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next     = cnt_reg + SB'(1);
                    cur_next     = cnt_reg + SB'(1);
                    cur_val_next = {op_reg.ident, op_reg.key};
                    state_next   = S_INS_W;
                end
            end
            S_INS_W:
            begin
                slot_we    = 1'b1;
                slot_waddr = AB'(cur_reg);
                slot_wdata = cur_val_reg;
                map_we     = 1'b1;
                map_waddr  = op_reg.ident;
                map_wdata  = cur_reg;
                state_next = S_UP_RD;
            end
            S_DEC_RD:
            begin
                if (map_rdata == '0 || map_rdata > cnt_reg)
                begin
                    st_next    = imhq_pkg::ST_BAD_ID;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = map_rdata;
                    slot_raddr = AB'(map_rdata);
                    state_next = S_DEC_CK;
                end
            end
            S_DEC_CK:
            begin
                if (imhq_pkg::key_lt(rd_key, op_reg.key))
                begin
                    st_next    = imhq_pkg::ST_INCREASE;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_val_next = {slot_rdata[SW-1:KW], op_reg.key};
                    slot_we      = 1'b1;
                    slot_waddr   = AB'(cur_reg);
                    slot_wdata   = {slot_rdata[SW-1:KW], op_reg.key};
                    state_next   = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                if (cur_reg <= SB'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    oth_next   = cur_reg >> 1;
                    slot_raddr = AB'(cur_reg >> 1);
                    state_next = S_UP_CK;
                end
            end
            S_UP_CK:
            begin
                if (imhq_pkg::key_lt(cur_key, rd_key))
                begin
                    // Swap child into parent slot.
                    oth_val_next = slot_rdata;
                    slot_we      = 1'b1;
                    slot_waddr   = AB'(oth_reg);
                    slot_wdata   = cur_val_reg;
                    map_we       = 1'b1;
                    map_waddr    = cur_id;
                    map_wdata    = oth_reg;
                    state_next   = S_UP_W2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UP_W2:
            begin
                slot_we    = 1'b1;
                slot_waddr = AB'(cur_reg);
                slot_wdata = oth_val_reg;
                map_we2    = 1'b1;
                map_waddr2 = oth_id;
                map_wdata2 = cur_reg;
                cur_next   = oth_reg;
                state_next = S_UP_RD2;
            end
            S_UP_RD2:
            begin
                state_next = S_UP_RD;
            end
            S_EX_RD1:
            begin
                slot_raddr = AB'(1);
                state_next = S_EX_RDL;
            end
            S_EX_RDL:
            begin
                oid_next   = slot_rdata[SW-1:KW];
                okey_next  = slot_rdata[KW-1:0];
                slot_raddr = AB'(cnt_reg);
                map_we     = 1'b1;
                map_waddr  = slot_rdata[SW-1:KW];
                map_wdata  = '0;
                state_next = S_EX_W;
            end
            S_EX_W:
            begin
                cnt_next = cnt_reg - SB'(1);
                cur_next = SB'(1);
                if (cnt_reg == SB'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_val_next = slot_rdata;
                    slot_we      = 1'b1;
                    slot_waddr   = AB'(1);
                    slot_wdata   = slot_rdata;
                    map_we       = 1'b1;
                    map_waddr    = slot_rdata[SW-1:KW];
                    map_wdata    = SB'(1);
                    state_next   = S_DN_RL;
                end
            end
            S_DN_RL:
            begin
                if ((cur_reg << 1) > cnt_reg || cur_reg[SB-1])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    slot_raddr = AB'(cur_reg << 1);
                    state_next = S_DN_RR;
                end
            end
            S_DN_RR:
            begin
                oth_next     = cur_reg << 1;
                oth_val_next = slot_rdata;
                if (((cur_reg << 1) + SB'(1)) > cnt_reg)
                begin
                    state_next = S_DN_CK;
                end
                else
                begin
                    slot_raddr = AB'((cur_reg << 1) + SB'(1));
                    state_next = S_DN_RD2;
                end
            end
            S_DN_RD2:
            begin
                // Right child present: prefer it only on strictly smaller key.
                if (imhq_pkg::key_lt(rd_key, oth_key))
                begin
                    oth_next     = oth_reg + SB'(1);
                    oth_val_next = slot_rdata;
                end
                state_next = S_DN_CK;
            end
            S_DN_CK:
            begin
                if (imhq_pkg::key_lt(oth_key, cur_key))
                begin
                    slot_we    = 1'b1;
                    slot_waddr = AB'(cur_reg);
                    slot_wdata = oth_val_reg;
                    map_we     = 1'b1;
                    map_waddr  = oth_id;
                    map_wdata  = cur_reg;
                    state_next = S_DN_W2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN_W2:
            begin
                slot_we    = 1'b1;
                slot_waddr = AB'(oth_reg);
                slot_wdata = cur_val_reg;
                map_we2    = 1'b1;
                map_waddr2 = cur_id;
                map_wdata2 = oth_reg;
                cur_next   = oth_reg;
                state_next = S_DN_RL;
            end
            S_DONE:
            begin
                // Wait for output register and pending map write to drain.
                if (out_free && !pend_we_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The reset sweep ends in S_DONE too but owes no result.
    logic load_out;
    assign load_out = (state_reg == S_DONE) && out_free && !pend_we_reg && !boot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            cap_reg       <= CB'(1024);
            cnt_reg       <= '0;
            sweep_reg     <= '0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (state_reg == S_SWEEP)
            begin
                sweep_reg <= sweep_reg + (MB+1)'(1);
            end
            else if (state_reg == S_DONE && state_next == S_IDLE)
            begin
                sweep_reg <= '0;
                boot_reg  <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= req;
        end
        cur_reg     <= cur_next;
        cur_val_reg <= cur_val_next;
        oth_reg     <= oth_next;
        oth_val_reg <= oth_val_next;
        st_reg      <= st_next;
        oid_reg     <= oid_next;
        okey_reg    <= okey_next;
        if (load_out)
        begin
            rsp_reg.status    <= st_reg;
            rsp_reg.out_ident <= oid_reg;
            rsp_reg.out_key   <= okey_reg;
            rsp_reg.count     <= CB'(cnt_reg);
            rsp_reg.is_empty  <= (cnt_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SB'(MAX_ENTRIES))
        else $error("entry count above heap size");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
    a_ok_extract: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rsp.status != imhq_pkg::ST_OK) |-> (rsp.out_ident == '0))
        else $error("error result carries an identifier");
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

>>> tb/tb_indexed_min_heap_queue.sv
module tb_indexed_min_heap_queue;

    localparam int HEAP_MAX = 1024;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int IBW = imhq_pkg::IDENT_BITS;
    localparam int KBW = imhq_pkg::KEY_W;
    localparam int CB = imhq_pkg::COUNT_BITS;
    localparam int NID = imhq_pkg::IDENT_SPACE;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    imhq_pkg::req_t req;
    logic out_valid;
    logic out_ready;
    imhq_pkg::rsp_t rsp;
    logic cfg_we;
    logic [CB-1:0] cfg_data;

    indexed_min_heap_queue #(.MAX_ENTRIES(HEAP_MAX)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req(req),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    // Predictor state: a shadow heap with its position map.
    logic [IBW-1:0]        pq_ident [1:HEAP_MAX];
    logic signed [KBW-1:0] pq_key [1:HEAP_MAX];
    int                    pq_slot [0:NID-1];
    int                    pq_count;
    int                    pq_capacity;

    imhq_pkg::rsp_t expected_rsps[$];
    int   fail_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Abort on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[indexed_min_heap_queue] ERROR");
            $finish;
        end
    end

    function automatic void pq_swap(input int a, input int b);
        logic [IBW-1:0]        t_id;
        logic signed [KBW-1:0] t_key;
        pq_slot[pq_ident[a]] = b;
        pq_slot[pq_ident[b]] = a;
        t_id = pq_ident[a];
        t_key = pq_key[a];
        pq_ident[a] = pq_ident[b];
        pq_key[a] = pq_key[b];
        pq_ident[b] = t_id;
        pq_key[b] = t_key;
    endfunction

    function automatic void pq_sift_up(input int i);
        while (i > 1 && pq_key[i] < pq_key[i / 2])
        begin
            pq_swap(i, i / 2);
            i = i / 2;
        end
    endfunction

    function automatic void pq_sift_down(input int i);
        int l;
        int r;
        int s;
        forever
        begin
            l = 2 * i;
            r = 2 * i + 1;
            s = i;
            if (l > pq_count) l = i;
            if (r > pq_count) r = i;
            if (pq_key[l] < pq_key[s]) s = l;
            if (pq_key[r] < pq_key[s]) s = r;
            if (s == i) break;
            pq_swap(i, s);
            i = s;
        end
    endfunction

    // Apply one operation to the shadow heap and return the result it owes.
    function automatic imhq_pkg::rsp_t heap_apply(input imhq_pkg::req_t r);
        imhq_pkg::rsp_t o;
        int   s;
        int   lim;
        o = '0;
        o.status = imhq_pkg::ST_OK;
        lim = (pq_capacity > HEAP_MAX) ? HEAP_MAX : pq_capacity;
        case (r.kind)
            imhq_pkg::KIND_CLEAR:
            begin
                for (int k = 0; k < NID; k++) pq_slot[k] = 0;
                pq_count = 0;
            end
            imhq_pkg::KIND_INSERT:
            begin
                if (pq_count >= lim)
                    o.status = imhq_pkg::ST_FULL;
                else if (pq_slot[r.ident] != 0)
                    o.status = imhq_pkg::ST_BAD_ID;
                else
                begin
                    pq_count++;
                    pq_ident[pq_count] = r.ident;
                    pq_key[pq_count] = r.key;
                    pq_slot[r.ident] = pq_count;
                    pq_sift_up(pq_count);
                end
            end
            imhq_pkg::KIND_EXTRACT:
            begin
                if (pq_count == 0)
                    o.status = imhq_pkg::ST_EMPTY;
                else
                begin
                    o.out_ident = pq_ident[1];
                    o.out_key = pq_key[1];
                    pq_swap(1, pq_count);
                    pq_slot[o.out_ident] = 0;
                    pq_count--;
                    pq_sift_down(1);
                end
            end
            default:
            begin
                s = pq_slot[r.ident];
                if (s == 0 || s > pq_count)
                    o.status = imhq_pkg::ST_BAD_ID;
                else if (r.key > pq_key[s])
                    o.status = imhq_pkg::ST_INCREASE;
                else
                begin
                    pq_key[s] = r.key;
                    pq_sift_up(s);
                end
            end
        endcase
        o.count = pq_count[CB-1:0];
        o.is_empty = (pq_count == 0);
        return o;
    endfunction

    function automatic imhq_pkg::req_t mk_req(input logic [1:0] k, input int id,
                                               input int key);
        imhq_pkg::req_t r;
        r.kind = k;
        r.ident = id[IBW-1:0];
        r.key = key;
        return r;
    endfunction

    // Offer one item, hold it until accepted, queue its prediction.
    // Valid stays high after acceptance; idle cycles or a drain drop it.
    // A pinned expectation, when given, is checked against the predictor too.
    task automatic send_item(input imhq_pkg::req_t r, input bit pinned,
                             input imhq_pkg::rsp_t pin);
        imhq_pkg::rsp_t e;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        e = heap_apply(r);
        if (pinned && e != pin)
        begin
            $error("directed row disagrees with predictor: %h vs %h", pin, e);
            fail_count++;
        end
        expected_rsps.push_back(e);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        // Leave room for any work still in flight.
        repeat (40) @(posedge clk);
    endtask

    task automatic write_capacity(input int value);
        cfg_we <= 1'b1;
        cfg_data <= value[CB-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        pq_capacity = value & 'h7FF;
    endtask

    // Receiver: stall at random, or hold off entirely during the pressure phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each taken result with the oldest prediction.
    always @(posedge clk)
    begin
        imhq_pkg::rsp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("result with nothing expected: %h", rsp);
                fail_count++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (rsp.status !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, rsp.status);
                    fail_count++;
                end
                if (rsp.out_ident !== e.out_ident)
                begin
                    $error("out_ident expected %0d got %0d", e.out_ident, rsp.out_ident);
                    fail_count++;
                end
                if (rsp.out_key !== e.out_key)
                begin
                    $error("out_key expected %0d got %0d", e.out_key, rsp.out_key);
                    fail_count++;
                end
                if (rsp.count !== e.count)
                begin
                    $error("count expected %0d got %0d", e.count, rsp.count);
                    fail_count++;
                end
                if (rsp.is_empty !== e.is_empty)
                begin
                    $error("is_empty expected %0d got %0d", e.is_empty, rsp.is_empty);
                    fail_count++;
                end
            end
        end
    end

    // Directed rows: pin marks rows whose result is read off at a glance.
    typedef struct {
        logic [1:0] kind;
        int         ident;
        int         key;
        bit         pin;
        logic [2:0] status;
        int         count;
    } row_t;

    row_t directed_rows[20] = '{
        '{imhq_pkg::KIND_EXTRACT,  0,    0,            1, imhq_pkg::ST_EMPTY,    0},
        '{imhq_pkg::KIND_DECREASE, 5,    0,            1, imhq_pkg::ST_BAD_ID,   0},
        '{imhq_pkg::KIND_INSERT,   1023, 32'h7FFFFFFF, 1, imhq_pkg::ST_OK,       1},
        '{imhq_pkg::KIND_INSERT,   0,    32'h80000000, 1, imhq_pkg::ST_OK,       2},
        '{imhq_pkg::KIND_INSERT,   1023, 5,            1, imhq_pkg::ST_BAD_ID,   2},
        '{imhq_pkg::KIND_INSERT,   7,    100,          1, imhq_pkg::ST_OK,       3},
        '{imhq_pkg::KIND_INSERT,   8,    100,          1, imhq_pkg::ST_OK,       4},
        '{imhq_pkg::KIND_DECREASE, 7,    101,          1, imhq_pkg::ST_INCREASE, 4},
        '{imhq_pkg::KIND_DECREASE, 7,    100,          1, imhq_pkg::ST_OK,       4},
        '{imhq_pkg::KIND_DECREASE, 1023, -50,          1, imhq_pkg::ST_OK,       4},
        '{imhq_pkg::KIND_DECREASE, 8,    32'h80000000, 1, imhq_pkg::ST_OK,       4},
        '{imhq_pkg::KIND_EXTRACT,  0,    0,            0, imhq_pkg::ST_OK,       3},
        '{imhq_pkg::KIND_EXTRACT,  0,    0,            0, imhq_pkg::ST_OK,       2},
        '{imhq_pkg::KIND_EXTRACT,  0,    0,            0, imhq_pkg::ST_OK,       1},
        '{imhq_pkg::KIND_INSERT,   512,  -1,           0, imhq_pkg::ST_OK,       2},
        '{imhq_pkg::KIND_EXTRACT,  0,    0,            0, imhq_pkg::ST_OK,       1},
        '{imhq_pkg::KIND_EXTRACT,  0,    0,            0, imhq_pkg::ST_OK,       0},
        '{imhq_pkg::KIND_INSERT,   3,    9,            1, imhq_pkg::ST_OK,       1},
        '{imhq_pkg::KIND_CLEAR,    0,    0,            1, imhq_pkg::ST_OK,       0},
        '{imhq_pkg::KIND_DECREASE, 3,    0,            1, imhq_pkg::ST_BAD_ID,   0}
    };

    // Random item: mostly inserts and extracts, idents drawn from the span, some noise.
    function automatic imhq_pkg::req_t random_item(input int id_span);
        imhq_pkg::req_t r;
        int   p;
        int   key;
        int   id;
        p = $urandom_range(99);
        key = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(400) - 200;
        id = $urandom_range(id_span - 1);
        if (p < 45)
            r = mk_req(imhq_pkg::KIND_INSERT, id, key);
        else if (p < 80)
            r = mk_req(imhq_pkg::KIND_EXTRACT, $urandom_range(1023), $urandom());
        else if (p < 99)
        begin
            // Mostly lower the key of an entry that is held.
            if (pq_count > 0 && $urandom_range(3) != 0)
            begin
                id = pq_ident[$urandom_range(pq_count - 1) + 1];
                key = pq_key[pq_slot[id]] - $urandom_range(50);
            end
            r = mk_req(imhq_pkg::KIND_DECREASE, id, key);
        end
        else
            r = mk_req(imhq_pkg::KIND_CLEAR, $urandom_range(1023), $urandom());
        return r;
    endfunction

    task automatic run_phase(input int n, input int idle, input int stall, input int span);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            send_item(random_item(span), 1'b0, '0);
        drain_results();
    endtask

    initial
    begin
        imhq_pkg::rsp_t pin;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        in_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        pq_count = 0;
        pq_capacity = 1024;
        for (int k = 0; k < NID; k++) pq_slot[k] = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, capacity at reset value.
        foreach (directed_rows[i])
        begin
            pin = '0;
            pin.status = directed_rows[i].status;
            pin.count = directed_rows[i].count[CB-1:0];
            pin.is_empty = (directed_rows[i].count == 0);
            send_item(mk_req(directed_rows[i].kind, directed_rows[i].ident,
                             directed_rows[i].key), directed_rows[i].pin, pin);
        end
        drain_results();

        // Capacity one: second insert is refused as full before duplication.
        write_capacity(1);
        pin = '0;
        pin.status = imhq_pkg::ST_OK;
        pin.count = CB'(1);
        send_item(mk_req(imhq_pkg::KIND_INSERT, 4, 4), 1'b1, pin);
        pin.status = imhq_pkg::ST_FULL;
        send_item(mk_req(imhq_pkg::KIND_INSERT, 4, 4), 1'b1, pin);
        drain_results();
        // Capacity zero refuses every insert.
        write_capacity(0);
        send_item(mk_req(imhq_pkg::KIND_INSERT, 9, 1), 1'b1, pin);
        drain_results();

        // Small capacity, full and refused inserts are common.
        write_capacity(6);
        run_phase(150, 0, 0, 16);
        // Largest capacity value saturates at the heap size.
        write_capacity(2047);
        run_phase(250, 74, 0, 1024);
        write_capacity(1024);
        run_phase(250, 0, 74, 64);
        write_capacity(40);
        run_phase(200, 28, 28, 128);

        // Pressure: hold the receiver off while items keep coming.
        write_capacity(1024);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_item(random_item(1024), 1'b0, '0);
        join
        drain_results();

        run_phase(250, 0, 0, 1024);
        // Clear pass sweeps the position map; allow for it.
        repeat (1100) @(posedge clk);

        if (fail_count == 0)
            $display("[indexed_min_heap_queue] OK");
        else
            $display("[indexed_min_heap_queue] ERROR");
        $finish;
    end

endmodule
